[rtl/core/drsc_pkg.sv]
// shared constants for the debounced rotation session counter
`default_nettype none

package drsc_pkg;

   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned DEBOUNCE_WIDTH  = 16;
   localparam int unsigned REPORT_WIDTH    = 16;

   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_DEBOUNCE = 2'd0;
   localparam csr_index_type CSR_INACTIVE = 2'd1;
   localparam csr_index_type CSR_SLEEP    = 2'd2;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd5;
   localparam logic [TIME_WIDTH-1:0]     INACTIVE_RESET = 32'd5000;
   localparam logic [TIME_WIDTH-1:0]     SLEEP_RESET    = 32'd20000;

endpackage : drsc_pkg

`default_nettype wire

[rtl/core/debounced_rotation_session_counter_core.sv]
// Usage: one transfer on the req channel is one millisecond tick carrying the
// sampled switch level and the link-ready flag. Every tick gives exactly one
// transfer on the rsp channel: report_valid with the finished session count,
// and sleep_request once the reported session has been idle past sleep_ticks.
// A tick's result is on rsp in the cycle after it is taken; a tick can be
// taken every cycle unless the receiver stalls. All edge, report and sleep
// checks for one tick are parallel 32-bit subtract-and-compare paths ahead
// of the single rsp register. On a stall the rsp register holds its item and
// req_ready drops until that item is taken; req_ready is high again in the
// cycle the rsp transfer completes, so a tick enters as the old result leaves.
// The csr port writes debounce_ticks (index 0), inactive_ticks (1) and
// sleep_ticks (2); other indexes are ignored. Write only while no tick is in
// flight.
// Reset clears the tick counter, the edge and activity times and the count,
// marks the session as reported, loads the register defaults (5, 5000, 20000)
// and empties the rsp register.
`default_nettype none

module debounced_rotation_session_counter_core
   import drsc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_switch_level,
   input  wire logic                      req_link_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_report_valid,
   output logic [REPORT_WIDTH-1:0]        rsp_report_count,
   output logic                           rsp_sleep_request,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // configuration
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff;
   logic [TIME_WIDTH-1:0]     inactive_ff;
   logic [TIME_WIDTH-1:0]     sleep_ff;

   // session state
   logic [TIME_WIDTH-1:0]  now_ff, now_in;
   logic                   prev_level_ff, prev_level_in;
   logic [TIME_WIDTH-1:0]  last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0]  last_activity_ff, last_activity_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   reported_ff, reported_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    report_valid_ff, report_valid_in;
   logic [REPORT_WIDTH-1:0] report_count_ff, report_count_in;
   logic                    sleep_request_ff, sleep_request_in;

   logic                  accept;
   logic [TIME_WIDTH-1:0] since_edge;
   logic [TIME_WIDTH-1:0] since_activity;
   logic                  edge_counted;
   logic                  report_now;
   logic                  sleep_now;
   logic [TIME_WIDTH-1:0] count_wide;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign since_edge     = now_ff - last_edge_ff;
   assign since_activity = now_ff - last_activity_ff;

   assign edge_counted = req_switch_level & ~prev_level_ff
                         & (since_edge > TIME_WIDTH'(debounce_ff));

   // a counted edge restarts the idle time; neither check fires on its tick
   assign report_now = req_link_ready & ~edge_counted & ~reported_ff
                       & (since_activity > inactive_ff);
   assign sleep_now  = req_link_ready & ~edge_counted & reported_ff
                       & (since_activity > sleep_ff);

   assign count_wide = TIME_WIDTH'(count_ff);

   always_comb begin
      now_in           = now_ff;
      prev_level_in    = prev_level_ff;
      last_edge_in     = last_edge_ff;
      last_activity_in = last_activity_ff;
      count_in         = count_ff;
      reported_in      = reported_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      report_valid_in  = report_valid_ff;
      report_count_in  = report_count_ff;
      sleep_request_in = sleep_request_ff;
      if (accept) begin
         now_in        = now_ff + 1'b1;
         prev_level_in = req_switch_level;
         if (edge_counted) begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            last_edge_in     = now_ff;
            last_activity_in = now_ff;
            reported_in      = 1'b0;
         end
         if (report_now) begin
            count_in         = '0;
            last_activity_in = now_ff;
            reported_in      = 1'b1;
         end
         rsp_valid_in     = 1'b1;
         report_valid_in  = report_now;
         report_count_in  = report_now ? count_wide[REPORT_WIDTH-1:0] : '0;
         sleep_request_in = sleep_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         inactive_ff <= INACTIVE_RESET;
         sleep_ff    <= SLEEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            CSR_INACTIVE: inactive_ff <= csr_wdata[TIME_WIDTH-1:0];
            CSR_SLEEP:    sleep_ff    <= csr_wdata[TIME_WIDTH-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff           <= '0;
         prev_level_ff    <= 1'b0;
         last_edge_ff     <= '0;
         last_activity_ff <= '0;
         count_ff         <= '0;
         reported_ff      <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         now_ff           <= now_in;
         prev_level_ff    <= prev_level_in;
         last_edge_ff     <= last_edge_in;
         last_activity_ff <= last_activity_in;
         count_ff         <= count_in;
         reported_ff      <= reported_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      report_valid_ff  <= report_valid_in;
      report_count_ff  <= report_count_in;
      sleep_request_ff <= sleep_request_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_report_valid  = report_valid_ff;
   assign rsp_report_count  = report_count_ff;
   assign rsp_sleep_request = sleep_request_ff;

endmodule : debounced_rotation_session_counter_core

`default_nettype wire

[rtl/core/drsc_checker.sv]
// port-level checks for the rotation session counter, bound to the core module
`default_nettype none

module drsc_checker
   import drsc_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_report_valid,
   input wire logic [REPORT_WIDTH-1:0]    rsp_report_count,
   input wire logic                       rsp_sleep_request
);

   // rsp register is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result blocks new ticks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("tick taken while result stalled");

   // an accepted tick must show a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no result");

   // a report and a sleep request never share one tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_report_valid && rsp_sleep_request))
      else $error("report and sleep request together");

   // count is zero on ticks without a report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_report_count == '0)
      else $error("nonzero count without report");

endmodule : drsc_checker

bind debounced_rotation_session_counter_core drsc_checker u_drsc_checker (.*);

`default_nettype wire
